### hdl/csvf_pkg.sv
package csvf_pkg;

  // Sizes of the block.
  localparam int MAX_COLUMNS   = 64;
  localparam int PATTERN_BYTES = 16;

  localparam int COL_SEL_W = 6;
  localparam int PLEN_W    = 5;
  localparam int CFG_W     = 64;
  localparam int PATTERN_W = 8 * PATTERN_BYTES;
  localparam int FC_W      = $clog2(MAX_COLUMNS + 1);
  localparam int COUNT_W   = 7;
  localparam int FILL_W    = $clog2(PATTERN_BYTES + 1);
  localparam int PIDX_W    = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int ROW_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Queue depths between the parts.
  localparam int OP_DEPTH   = 2;
  localparam int OP_PTR_W   = $clog2(OP_DEPTH);
  localparam int OP_CNT_W   = $clog2(OP_DEPTH + 1);
  localparam int RES_DEPTH  = 2;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  // Special characters.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH  = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CONTENT,
    OP_COMMA
  } op_kind_t;

  // One classified byte, as handed from the front to the back.
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       row_end;
    logic       eof;
  } op_t;

  typedef struct packed {
    logic               row_matched;
    logic [COUNT_W-1:0] column_count;
    logic [ROW_W-1:0]   row_number;
    logic               last_row;
  } res_t;

  typedef struct packed {
    logic [COL_SEL_W-1:0] column_select;
    logic [PLEN_W-1:0]    match_length;
    logic [PATTERN_W-1:0] pattern;
  } cfg_t;

endpackage

### hdl/csvf_front.sv
module csvf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     data_byte,
  input  logic           end_of_file,
  output logic           op_valid,
  input  logic           op_pop,
  output csvf_pkg::op_t  op
);
  import csvf_pkg::*;

  logic                in_quotes_r, in_quotes_nxt;
  op_t                 q_r [OP_DEPTH];
  logic [OP_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OP_CNT_W-1:0] cnt_r, cnt_nxt;
  op_t                 cls;
  logic                accept, take;

  assign full     = (cnt_r == OP_CNT_W'(OP_DEPTH));
  assign accept   = push && !full;
  assign op_valid = (cnt_r != '0);
  assign take     = op_pop && op_valid;
  assign op       = q_r[rd_ptr_r];

  // Quoted mode is tracked here so that a comma is resolved on arrival.
  always_comb begin
    cls.data    = data_byte;
    cls.eof     = end_of_file;
    cls.row_end = end_of_file;
    cls.kind    = OP_CONTENT;
    in_quotes_nxt = in_quotes_r;
    if (data_byte == CH_NEWLINE) begin
      cls.kind    = OP_NONE;
      cls.row_end = 1'b1;
    end else if (data_byte == CH_RETURN) begin
      cls.kind = OP_NONE;
    end else if (data_byte == CH_QUOTE) begin
      cls.kind      = OP_NONE;
      in_quotes_nxt = !in_quotes_r;
    end else if (data_byte == CH_COMMA && !in_quotes_r) begin
      cls.kind = OP_COMMA;
    end
    if (cls.row_end) begin
      in_quotes_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        in_quotes_r <= in_quotes_nxt;
        wr_ptr_r    <= wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### hdl/csvf_back.sv
module csvf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  csvf_pkg::cfg_t cfg,
  input  logic           op_valid,
  output logic           op_pop,
  input  csvf_pkg::op_t  op,
  output logic           res_empty,
  input  logic           res_pop,
  output csvf_pkg::res_t res
);
  import csvf_pkg::*;

  logic [FC_W-1:0]      fc_r, fc_op, fc_nxt;
  logic [FILL_W-1:0]    fill_r, fill_op, fill_nxt;
  logic                 match_r, match_op, match_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [7:0]           recent_r [PATTERN_BYTES];
  logic [7:0]           window [PATTERN_BYTES];
  logic [7:0]           pat_bytes [PATTERN_BYTES];
  logic [PLEN_W-1:0]    used_len;
  logic [FILL_W-1:0]    fill_inc;
  logic [PATTERN_BYTES-1:0] byte_ok;
  logic                 selected, hit, take;
  res_t                 res_new;
  res_t                 rq_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] rq_wr_r, rq_rd_r;
  logic [RES_CNT_W-1:0] rq_cnt_r, rq_cnt_nxt;
  logic                 rq_push, rq_pop, rq_space;

  assign used_len = (cfg.match_length > PLEN_W'(PATTERN_BYTES)) ?
                    PLEN_W'(PATTERN_BYTES) : cfg.match_length;
  assign selected = (fc_r == FC_W'(cfg.column_select));
  assign fill_inc = (fill_r < FILL_W'(PATTERN_BYTES)) ? fill_r + 1'b1 : fill_r;

  // Window after shifting in the byte, newest at index zero; window entry j
  // is checked against pattern byte used_len-1-j.
  always_comb begin
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      pat_bytes[j] = cfg.pattern[8*j +: 8];
      window[j]    = (j == 0) ? op.data : recent_r[(j == 0) ? 0 : j - 1];
    end
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      logic [PLEN_W-1:0] pidx;
      pidx = used_len - PLEN_W'(1) - PLEN_W'(j);
      byte_ok[j] = (PLEN_W'(j) >= used_len) ||
                   (window[j] == pat_bytes[pidx[PIDX_W-1:0]]);
    end
    hit = (used_len != '0) && (PLEN_W'(fill_inc) >= used_len) && (&byte_ok);
  end

  assign rq_space = (rq_cnt_r != RES_CNT_W'(RES_DEPTH));
  assign take     = op_valid && (!op.row_end || rq_space);
  assign op_pop   = take;
  assign rq_push  = take && op.row_end;

  // Effect of the byte itself.
  always_comb begin
    fc_op    = fc_r;
    fill_op  = fill_r;
    match_op = match_r;
    case (op.kind)
      OP_CONTENT: begin
        if (selected) begin
          fill_op = fill_inc;
          if (hit) begin
            match_op = 1'b1;
          end
        end
      end
      OP_COMMA: begin
        if (fc_r < FC_W'(MAX_COLUMNS)) begin
          fc_op = fc_r + 1'b1;
        end
        fill_op = '0;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_comb begin
    res_new.row_matched  = (used_len == '0) || match_op;
    res_new.column_count = (fc_op >= FC_W'(MAX_COLUMNS)) ?
                           COUNT_W'(MAX_COLUMNS) : COUNT_W'(fc_op + 1'b1);
    res_new.row_number   = row_r;
    res_new.last_row     = op.eof;
  end

  // A row end clears the row state after its result is formed.
  always_comb begin
    fc_nxt    = fc_r;
    fill_nxt  = fill_r;
    match_nxt = match_r;
    row_nxt   = row_r;
    if (take) begin
      fc_nxt    = fc_op;
      fill_nxt  = fill_op;
      match_nxt = match_op;
      if (op.row_end) begin
        fc_nxt    = '0;
        fill_nxt  = '0;
        match_nxt = 1'b0;
        row_nxt   = op.eof ? '0 : row_r + 1'b1;
      end
    end
  end

  assign rq_pop    = res_pop && (rq_cnt_r != '0);
  assign res_empty = (rq_cnt_r == '0);
  assign res       = rq_r[rq_rd_r];

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (rq_push && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + 1'b1;
    end else if (!rq_push && rq_pop) begin
      rq_cnt_nxt = rq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r     <= '0;
      fill_r   <= '0;
      match_r  <= 1'b0;
      row_r    <= '0;
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      fc_r     <= fc_nxt;
      fill_r   <= fill_nxt;
      match_r  <= match_nxt;
      row_r    <= row_nxt;
      rq_cnt_r <= rq_cnt_nxt;
      if (rq_push) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && op.kind == OP_CONTENT && selected) begin
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        recent_r[j] <= window[j];
      end
    end
    if (rq_push) begin
      rq_r[rq_wr_r] <= res_new;
    end
  end

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue count beyond its depth");

  a_rq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> (rq_space || rq_pop))
    else $error("result pushed into a full queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(PATTERN_BYTES))
    else $error("field fill beyond pattern size");

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FC_W'(MAX_COLUMNS))
    else $error("field counter beyond column limit");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && op.row_end && op.eof) |=> (row_r == '0 && fc_r == '0))
    else $error("row numbering did not restart after end of file");

endmodule

### hdl/csv_column_substring_filter.sv
// CSV column substring filter.
//
// Bytes of CSV text enter on the input queue port: an item (one byte plus
// an end-of-file flag) is taken at a clock edge where in_push is high and
// in_full is low. For each row that ends (newline, or the byte flagged as
// end of file) one result item is placed on the output queue: whether the
// selected column contains the pattern, the column count and the row
// number. The oldest result is shown while out_empty is low and is taken
// at an edge where out_pop is high.
// The block takes one byte per clock cycle while in_full is low. A short
// queue of classified bytes separates the byte classifier from the row
// logic, and a two-entry result queue sits at the output. When the
// receiver stalls, results collect in the result queue, then the byte
// queue fills and in_full rises until out_pop resumes. Reset clears all
// row state, the row numbering and the configuration registers (pattern
// empty, column zero). The user must write configuration through cfg_we,
// cfg_index and cfg_data only while the block holds no pending items; the
// block itself does not enforce this.
module csv_column_substring_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_end_of_file,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_row_matched,
  output logic [csvf_pkg::COUNT_W-1:0]       out_column_count,
  output logic [csvf_pkg::ROW_W-1:0]         out_row_number,
  output logic                               out_last_row,
  input  logic                               cfg_we,
  input  logic [csvf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csvf_pkg::CFG_W-1:0]         cfg_data
);
  import csvf_pkg::*;

  logic [COL_SEL_W-1:0] column_select_r;
  logic [PLEN_W-1:0]    match_length_r;
  logic [CFG_W-1:0]     pattern_low_r;
  logic [CFG_W-1:0]     pattern_high_r;
  cfg_t                 cfg;
  op_t                  op;
  logic                 op_valid, op_pop;
  res_t                 res;

  // Configuration registers. An index outside the list is ignored by the
  // default arm; all four indexes of a two-bit port are used here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_select_r <= '0;
      match_length_r  <= '0;
      pattern_low_r   <= '0;
      pattern_high_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMN_SELECT: column_select_r <= cfg_data[COL_SEL_W-1:0];
        CFG_MATCH_LENGTH:  match_length_r  <= cfg_data[PLEN_W-1:0];
        CFG_PATTERN_LOW:   pattern_low_r   <= cfg_data;
        CFG_PATTERN_HIGH:  pattern_high_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pattern byte zero sits in the lowest bits of the low register.
  assign cfg.column_select = column_select_r;
  assign cfg.match_length  = match_length_r;
  assign cfg.pattern       = {pattern_high_r, pattern_low_r};

  // The front resolves quoting and turns each byte into a simple operation.
  csvf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .op_valid    (op_valid),
    .op_pop      (op_pop),
    .op          (op)
  );

  // The back keeps the row state, runs the pattern search and queues results.
  csvf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .op_valid  (op_valid),
    .op_pop    (op_pop),
    .op        (op),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res       (res)
  );

  assign out_row_matched  = res.row_matched;
  assign out_column_count = res.column_count;
  assign out_row_number   = res.row_number;
  assign out_last_row     = res.last_row;

endmodule
